@@ rtl/core/ilds_pkg.sv @@
package ilds_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FOUND_W  = 6;
  localparam int unsigned LEN_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_TAKE_PREV = 2'd2,
    CELL_TAKE_NEXT = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;       // entry update for this cycle
    logic     capture;  // latch the compare result
    logic     valid;    // cell lies below the fill count
  } cell_ctrl_t;

endpackage

@@ rtl/core/integer_list_deque_with_search_unit.sv @@
// Bounded deque of up to CAPACITY signed 32-bit entries with search. The
// request is taken when start_i is high and busy_o low, busy_o is high for
// the next cycle, and the result appears on the cycle after that with done_o
// high for exactly one cycle; a new request can be taken in that same cycle.
// Entries sit in a row of cells that shift toward or away from the front in
// one step and all compare against the search key in parallel; the busy cycle
// resolves the first matching position. The receiver must take every result as
// it comes.
module integer_list_deque_with_search_unit
  import ilds_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [OP_W-1:0]            op_i,
  input  logic signed [DATA_W-1:0]   value_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [FOUND_W-1:0]         found_index_o,
  output logic [LEN_W-1:0]           length_o
);

  logic                accept;
  op_e                 op;
  logic                ins_ok, rem_ok;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                pend_q;
  logic                pend_search_q;
  status_e             pend_status_q, pend_status_d;

  logic                done_q;
  status_e             status_q, status_d;
  logic [FOUND_W-1:0]  found_q, found_d;
  logic [LEN_W-1:0]    length_q;

  logic signed [DATA_W-1:0] entry  [CAPACITY];
  logic [CAPACITY-1:0]      match;
  cell_ctrl_t               ctrl   [CAPACITY];

  logic                first_found;
  logic [IDX_W-1:0]    first_index;

  assign accept = start_i && !pend_q;
  assign op     = op_e'(op_i);
  assign ins_ok = count_q < CNT_W'(CAPACITY);
  assign rem_ok = count_q != '0;

  always_comb begin
    count_d       = count_q;
    pend_status_d = ST_DONE;
    unique case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ins_ok) count_d = count_q + CNT_W'(1);
        else        pend_status_d = ST_FULL;
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (rem_ok) count_d = count_q - CNT_W'(1);
        else        pend_status_d = ST_EMPTY;
      end
      OP_SEARCH: pend_status_d = ST_NOT_FOUND;
      default:   pend_status_d = ST_DONE;
    endcase
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [DATA_W-1:0] prev_w, next_w;

    if (k == 0) begin : g_head
      assign prev_w = value_i;
    end else begin : g_body
      assign prev_w = entry[k-1];
    end
    if (k == CAPACITY - 1) begin : g_tail
      assign next_w = entry[k];
    end else begin : g_inner
      assign next_w = entry[k+1];
    end

    always_comb begin
      ctrl[k].op      = CELL_HOLD;
      ctrl[k].capture = accept;
      ctrl[k].valid   = CNT_W'(k) < count_q;
      if (accept) begin
        unique case (op)
          OP_PUSH_FRONT: if (ins_ok) ctrl[k].op = CELL_TAKE_PREV;
          OP_PUSH_BACK:  if (ins_ok && count_q == CNT_W'(k)) ctrl[k].op = CELL_LOAD;
          OP_POP_FRONT:  if (rem_ok) ctrl[k].op = CELL_TAKE_NEXT;
          default:       ctrl[k].op = CELL_HOLD;
        endcase
      end
    end

    ilds_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[k]),
      .data_i  (value_i),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .entry_o (entry[k]),
      .match_o (match[k])
    );
  end

  ilds_first_match u_first_match (
    .match_i (match),
    .found_o (first_found),
    .index_o (first_index)
  );

  always_comb begin
    status_d = pend_status_q;
    found_d  = '0;
    if (pend_search_q && first_found) begin
      status_d = ST_DONE;
      found_d  = FOUND_W'(first_index);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (accept) count_q <= count_d;
      pend_q <= accept;
      done_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_search_q <= (op == OP_SEARCH);
      pend_status_q <= pend_status_d;
      length_q      <= LEN_W'(count_d);
    end
    if (pend_q) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  assign busy_o        = pend_q;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign length_o      = length_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o ##1 done_o)
    else $error("accepted transaction did not complete in two cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_o |=> !busy_o)
    else $error("busy held longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> length_o == LEN_W'(CAPACITY))
    else $error("full status with list not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_EMPTY) |-> length_o == '0)
    else $error("empty status with entries held");

endmodule

@@ rtl/core/ilds_cell.sv @@
module ilds_cell
  import ilds_pkg::*;
(
  input  logic                      clk_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0]  data_i,
  input  logic signed [DATA_W-1:0]  prev_i,
  input  logic signed [DATA_W-1:0]  next_i,
  output logic signed [DATA_W-1:0]  entry_o,
  output logic                      match_o
);

  logic signed [DATA_W-1:0] entry_q, entry_d;
  logic                     match_q, match_d;

  always_comb begin
    unique case (ctrl_i.op)
      CELL_HOLD:      entry_d = entry_q;
      CELL_LOAD:      entry_d = data_i;
      CELL_TAKE_PREV: entry_d = prev_i;
      CELL_TAKE_NEXT: entry_d = next_i;
      default:        entry_d = entry_q;
    endcase
  end

  // compare against the old contents; a search never moves entries
  assign match_d = ctrl_i.capture ? (ctrl_i.valid && (entry_q == data_i)) : match_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

@@ rtl/core/ilds_first_match.sv @@
module ilds_first_match
  import ilds_pkg::*;
(
  input  logic [CAPACITY-1:0] match_i,
  output logic                found_o,
  output logic [IDX_W-1:0]    index_o
);

  always_comb begin
    found_o = 1'b0;
    index_o = '0;
    // scan from the back so the lowest set position wins
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match_i[k]) begin
        found_o = 1'b1;
        index_o = IDX_W'(k);
      end
    end
  end

endmodule
